@@ rtl/query_frame_responder_macros.svh @@
// Assertion macros used by the reply sender of the query frame responder.
`ifndef QUERY_FRAME_RESPONDER_MACROS_SVH
`define QUERY_FRAME_RESPONDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qfr_pkg.sv @@
`default_nettype none

package qfr_pkg;

    // Query frame ">QS1?" and its checksum position.
    localparam int QUERY_LEN = 5;

    localparam logic [7:0] CHAR_START  = 8'h3E; // '>'
    localparam logic [7:0] CHAR_Q      = 8'h51; // 'Q'
    localparam logic [7:0] CHAR_S      = 8'h53; // 'S'
    localparam logic [7:0] CHAR_ONE    = 8'h31; // '1'
    localparam logic [7:0] CHAR_QMARK  = 8'h3F; // '?'
    localparam logic [7:0] CHAR_COLON  = 8'h3A; // ':'
    localparam logic [7:0] CHAR_C      = 8'h43; // 'C'
    localparam logic [3:0] ASCII_DIGIT = 4'h3;  // high nibble of '0'..'9'

    // Matcher positions.
    localparam logic [2:0] POS_IDLE     = 3'd0;
    localparam logic [2:0] POS_CHECKSUM = 3'd5;

    // Reply frame layout.
    localparam int REPLY_LEN   = 11;
    localparam int DIGIT_COUNT = 5;

    localparam logic [3:0] IDX_START  = 4'd0;
    localparam logic [3:0] IDX_S      = 4'd1;
    localparam logic [3:0] IDX_ONE    = 4'd2;
    localparam logic [3:0] IDX_COLON  = 4'd3;
    localparam logic [3:0] IDX_DIGIT0 = 4'd4;
    localparam logic [3:0] IDX_DIGIT4 = 4'd8;
    localparam logic [3:0] IDX_C      = 4'd9;
    localparam logic [3:0] IDX_SUM    = 4'd10;

    // Reciprocal of ten: (v * DIV10_MUL) >> DIV10_SHIFT equals v / 10 for any 16-bit v.
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] temperature;
    } qfr_query_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } qfr_reply_t;

    // Request from the matcher to the reply sender.
    typedef struct packed {
        logic        valid;
        logic [15:0] temperature;
    } qfr_req_t;

    function automatic logic [7:0] query_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CHAR_START;
            3'd1:    c = CHAR_Q;
            3'd2:    c = CHAR_S;
            3'd3:    c = CHAR_ONE;
            3'd4:    c = CHAR_QMARK;
            default: c = CHAR_START;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/qfr_matcher.sv @@
`default_nettype none

module qfr_matcher
    import qfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       query_valid,
    output logic            query_ready,
    input  wire qfr_query_t query,
    output qfr_req_t        req,
    input  wire logic       req_ready
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic        req_valid_reg, req_valid_next;
    logic [15:0] req_temp_reg, req_temp_next;
    logic        accept;

    // Only a checksum byte can raise a request, so only that position waits for the sender.
    assign query_ready = !((pos_reg == POS_CHECKSUM) && req_valid_reg);
    assign accept      = query_valid && query_ready;

    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        req_valid_next = req_valid_reg && !req_ready;
        req_temp_next  = req_temp_reg;
        if (accept)
        begin
            if (pos_reg == POS_IDLE || pos_reg > POS_CHECKSUM)
            begin
                if (query.rx_byte == CHAR_START)
                begin
                    pos_next = 3'd1;
                    sum_next = query.rx_byte;
                end
                else
                begin
                    pos_next = POS_IDLE;
                end
            end
            else if (pos_reg < POS_CHECKSUM)
            begin
                if (query.rx_byte == query_char(pos_reg))
                begin
                    pos_next = pos_reg + 3'd1;
                    sum_next = sum_reg + query.rx_byte;
                end
                else
                begin
                    pos_next = POS_IDLE;
                end
            end
            else
            begin
                pos_next = POS_IDLE;
                if (query.rx_byte == sum_reg)
                begin
                    req_valid_next = 1'b1;
                    req_temp_next  = query.temperature;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            sum_reg       <= 8'd0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_temp_reg <= req_temp_next;
    end

    assign req.valid       = req_valid_reg;
    assign req.temperature = req_temp_reg;

endmodule

`default_nettype wire

@@ rtl/qfr_sender.sv @@
`default_nettype none

`include "query_frame_responder_macros.svh"

module qfr_sender
    import qfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire qfr_req_t req,
    output logic          req_ready,
    output logic          reply_valid,
    input  wire logic     reply_ready,
    output qfr_reply_t    reply
);

    logic        busy_reg, busy_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  conv_cnt_reg, conv_cnt_next;
    logic [15:0] value_reg, value_next;
    logic [19:0] digits_reg, digits_next;
    logic [7:0]  csum_reg, csum_next;
    logic        out_valid_reg, out_valid_next;
    qfr_reply_t  out_reg, out_next;

    logic        start;
    logic        conv_done;
    logic        emit;
    logic [32:0] product;
    logic [15:0] quotient;
    logic [15:0] remainder;
    logic [7:0]  cur_byte;

    assign req_ready = !busy_reg;
    assign start     = req.valid && !busy_reg;
    assign conv_done = (conv_cnt_reg == 3'(DIGIT_COUNT));

    // Decimal digits are produced least significant first, one division by ten a cycle.
    assign product   = value_reg * DIV10_MUL;
    assign quotient  = 16'(product >> DIV10_SHIFT);
    assign remainder = value_reg - ((quotient << 3) + (quotient << 1));

    assign emit = busy_reg && (!out_valid_reg || reply_ready)
                  && (idx_reg < IDX_DIGIT0 || conv_done);

    always_comb
    begin
        case (idx_reg)
            IDX_START: cur_byte = CHAR_START;
            IDX_S:     cur_byte = CHAR_S;
            IDX_ONE:   cur_byte = CHAR_ONE;
            IDX_COLON: cur_byte = CHAR_COLON;
            IDX_C:     cur_byte = CHAR_C;
            IDX_SUM:   cur_byte = csum_reg;
            default:   cur_byte = {ASCII_DIGIT, digits_reg[19:16]};
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        conv_cnt_next  = conv_cnt_reg;
        value_next     = value_reg;
        digits_next    = digits_reg;
        csum_next      = csum_reg;
        out_valid_next = out_valid_reg && !reply_ready;
        out_next       = out_reg;

        if (start)
        begin
            busy_next     = 1'b1;
            idx_next      = IDX_START;
            conv_cnt_next = 3'd0;
            value_next    = req.temperature;
            csum_next     = 8'd0;
        end
        else if (busy_reg)
        begin
            if (!conv_done)
            begin
                conv_cnt_next = conv_cnt_reg + 3'd1;
                value_next    = quotient;
                digits_next   = {remainder[3:0], digits_reg[19:4]};
            end
            if (emit)
            begin
                out_valid_next     = 1'b1;
                out_next.tx_byte   = cur_byte;
                out_next.last_byte = (idx_reg == IDX_SUM);
                csum_next          = csum_reg + cur_byte;
                idx_next           = idx_reg + 4'd1;
                if (idx_reg >= IDX_DIGIT0 && idx_reg <= IDX_DIGIT4)
                begin
                    digits_next = {digits_reg[15:0], 4'd0};
                end
                if (idx_reg == IDX_SUM)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_START;
            conv_cnt_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            conv_cnt_reg  <= conv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        digits_reg <= digits_next;
        csum_reg   <= csum_next;
        out_reg    <= out_next;
    end

    assign reply_valid = out_valid_reg;
    assign reply       = out_reg;

    `QFR_ASSERT_NOW(a_digits_ready, clk, rst_n, emit && idx_reg >= IDX_DIGIT0, conv_done, "digit sent before conversion finished")
    `QFR_ASSERT_NEXT(a_start_loads, clk, rst_n, start, busy_reg && idx_reg == IDX_START, "reply did not start at its first byte")
    `QFR_ASSERT_NEXT(a_last_frees, clk, rst_n, emit && idx_reg == IDX_SUM, !busy_reg && reply.last_byte, "sender still busy after the final byte")
    `QFR_ASSERT_NOW(a_idx_range, clk, rst_n, busy_reg, idx_reg <= IDX_SUM, "reply index beyond the frame")

endmodule

`default_nettype wire

@@ rtl/query_frame_responder.sv @@
// Query frame responder.
// The query channel carries one received serial word per handshake (query_valid,
// query_ready, query): the byte itself and the temperature to report. The block
// looks for the frame ">QS1?" followed by a checksum word equal to the 8-bit sum
// of those five characters; a wrong character sends the matcher back to idle.
// When the checksum matches, the reply channel (reply_valid, reply_ready, reply)
// delivers eleven words: ">S1:", five zero-padded decimal digits of the
// temperature sampled with the checksum word, 'C', and the 8-bit sum of those
// ten bytes, which is flagged by last_byte.
// The first reply word reaches the output register after the request has passed
// the matcher's request register and started the sender. One division by ten a
// cycle converts the temperature while the fixed header goes out, and the first
// digit waits for the fifth of those steps.
// Query words are taken one per cycle while a reply is being sent; only a
// checksum word arriving while a requested reply still waits to start is held off.
// A stalled receiver freezes the output register and the sender's byte index.
// Reset clears the matcher, drops any pending or partly sent reply and empties
// the output register.
`default_nettype none

module query_frame_responder
    import qfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       query_valid,
    output logic            query_ready,
    input  wire qfr_query_t query,
    output logic            reply_valid,
    input  wire logic       reply_ready,
    output qfr_reply_t      reply
);

    // Request handed from the frame matcher to the reply sender.
    qfr_req_t req;
    logic     req_ready;

    // Frame matcher: follows the query characters and checks the checksum word.
    qfr_matcher u_matcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .req         (req),
        .req_ready   (req_ready)
    );

    // Reply sender: converts the temperature to decimal and streams the frame.
    qfr_sender u_sender (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .req_ready   (req_ready),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply)
    );

endmodule

`default_nettype wire
